// File: design/krt_pkg.sv
// Shared types and constants for the keyed record table.
// Holds the request and result structs and the controller/datapath interface.
// No dependencies.
package krt_pkg;

    localparam int DEFAULT_DEPTH = 128;
    localparam int KEY_W         = 32;
    localparam int PAY_W         = 64;
    localparam int STATUS_W      = 3;
    localparam int SLOT_W        = 7;
    localparam int COUNT_W       = 8;

    // Request codes.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_RENAME = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;
    localparam logic [1:0] REQ_SEARCH = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd4;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] new_key;
        logic [PAY_W-1:0]        payload_in;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [PAY_W-1:0]    payload_out;
        logic [COUNT_W-1:0]  entry_count;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic issue;
        logic commit;
        logic load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic addr_last;
        logic out_free;
    } t_sts;

endpackage

// File: design/keyed_record_table.sv
// Top level of the keyed record table.
// Instantiates krt_ctrl and krt_datapath; depends on krt_pkg.

// A table of DEPTH keyed records, each a 32-bit key and a 64-bit payload; an
// empty slot has its occupancy bit clear. Each request (insert, rename, delete or
// search) is answered by exactly one result that carries a status, the slot
// involved, the payload on a successful search, and the occupancy count after
// the request. Requests using key zero, or renaming to key zero, are rejected as
// invalid and leave the table unchanged. Every request walks all DEPTH slots
// through the single read port of the key memory, one slot per cycle, then
// finishes the last compare in a drain state, decides and writes back in a
// decide state and loads the result in a fetch state. Only one request is
// processed at a time and the input is stalled while it is in progress. The
// result sits in an output register, so a new request is accepted while the
// previous result still waits to be taken; a request whose result is ready
// waits in the load step for as long as the previous result stays stalled.
// Slot occupancy lives in flip-flops cleared by reset, so the table is empty
// right after reset with no clearing pass. Slot indexes are reported in 7 bits
// and the count in 8 bits.
module keyed_record_table #(
    parameter int DEPTH = krt_pkg::DEFAULT_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  krt_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output krt_pkg::t_res o_out_res
);
    import krt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The controller sequences each request: capture, scan, decide, fetch
    // payload and hand the result to the output register.
    krt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the memories, the compare stage and the result.
    krt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

endmodule

// File: design/krt_ctrl.sv
// Sequencer for the keyed record table: accept, scan, decide, fetch, respond.
// Depends on krt_pkg.
module krt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  krt_pkg::t_sts i_sts,
    output krt_pkg::t_cmd o_cmd
);
    import krt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_FETCH  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.commit = 1'b1;
                n_state      = S_FETCH;
            end
            S_FETCH: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/krt_datapath.sv
// Datapath of the keyed record table: key and payload memories, occupancy bits,
// scan comparators, decision logic and the result register. Depends on krt_pkg.
module krt_datapath #(
    parameter int DEPTH = krt_pkg::DEFAULT_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  krt_pkg::t_req i_req,
    input  krt_pkg::t_cmd i_cmd,
    output krt_pkg::t_sts o_sts,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output krt_pkg::t_res o_out_res
);
    import krt_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [KEY_W-1:0]    r_key_mem [DEPTH];
    logic [PAY_W-1:0]    r_pay_mem [DEPTH];
    logic [DEPTH-1:0]    r_vld;

    t_req                r_req;
    logic [IW-1:0]       r_addr;
    logic [IW-1:0]       r_cmp_idx;
    logic                r_cmp_en;
    logic                r_rd_vld;
    logic [KEY_W-1:0]    r_rd_key;

    logic                r_emp_found;
    logic [IW-1:0]       r_emp_idx;
    logic                r_k_found;
    logic [IW-1:0]       r_k_idx;
    logic                r_nk_found;

    logic [CW-1:0]       r_count;
    logic [STATUS_W-1:0] r_res_status;
    logic [IW-1:0]       r_res_idx;
    logic                r_res_pay;
    logic [PAY_W-1:0]    r_pay_rd;
    logic                r_out_vld;
    t_res                r_out;

    logic                hit_k;
    logic                hit_nk;
    logic [STATUS_W-1:0] n_status;
    logic [IW-1:0]       n_idx;
    logic                n_pay_sel;
    logic                wr_key;
    logic [KEY_W-1:0]    wr_key_val;
    logic                wr_pay;
    logic [IW-1:0]       wr_idx;
    logic                set_vld;
    logic                clr_vld;
    logic                cnt_inc;
    logic                cnt_dec;

    assign hit_k  = r_rd_vld && (r_rd_key == r_req.key);
    assign hit_nk = r_rd_vld && (r_rd_key == r_req.new_key);

    // Outcome of the request once the scan has finished.
    always_comb begin
        n_status   = ST_OK;
        n_idx      = '0;
        n_pay_sel  = 1'b0;
        wr_key     = 1'b0;
        wr_key_val = r_req.key;
        wr_pay     = 1'b0;
        wr_idx     = r_k_idx;
        set_vld    = 1'b0;
        clr_vld    = 1'b0;
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        if (r_req.key == '0 || (r_req.req_type == REQ_RENAME && r_req.new_key == '0)) begin
            n_status = ST_INVALID;
        end else begin
            case (r_req.req_type)
                REQ_INSERT: begin
                    if (!r_emp_found) begin
                        n_status = ST_FULL;
                    end else if (r_k_found) begin
                        n_status = ST_DUP;
                    end else begin
                        n_idx   = r_emp_idx;
                        wr_idx  = r_emp_idx;
                        wr_key  = 1'b1;
                        wr_pay  = 1'b1;
                        set_vld = 1'b1;
                        cnt_inc = 1'b1;
                    end
                end
                REQ_RENAME: begin
                    if (!r_k_found) begin
                        n_status = ST_NOTFOUND;
                    end else if (r_nk_found) begin
                        n_status = ST_DUP;
                    end else begin
                        n_idx      = r_k_idx;
                        wr_key     = 1'b1;
                        wr_key_val = r_req.new_key;
                    end
                end
                REQ_DELETE: begin
                    if (!r_k_found) begin
                        n_status = ST_NOTFOUND;
                    end else begin
                        n_idx   = r_k_idx;
                        clr_vld = 1'b1;
                        cnt_dec = 1'b1;
                    end
                end
                REQ_SEARCH: begin
                    if (!r_k_found) begin
                        n_status = ST_NOTFOUND;
                    end else begin
                        n_idx     = r_k_idx;
                        n_pay_sel = 1'b1;
                    end
                end
                default: begin
                    n_status = ST_INVALID;
                end
            endcase
        end
    end

    // Memories and payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_key) begin
            r_key_mem[wr_idx] <= wr_key_val;
        end
        if (i_cmd.commit && wr_pay) begin
            r_pay_mem[wr_idx] <= r_req.payload_in;
        end
        r_rd_key <= r_key_mem[r_addr];
        r_pay_rd <= r_pay_mem[r_k_idx];
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.issue) begin
            r_cmp_idx <= r_addr;
        end
        if (r_cmp_en && !r_emp_found && !r_rd_vld) begin
            r_emp_idx <= r_cmp_idx;
        end
        if (r_cmp_en && !r_k_found && hit_k) begin
            r_k_idx <= r_cmp_idx;
        end
        if (i_cmd.commit) begin
            r_res_status <= n_status;
            r_res_idx    <= n_idx;
            r_res_pay    <= n_pay_sel;
        end
        if (i_cmd.load) begin
            r_out.status      <= r_res_status;
            r_out.slot_index  <= SLOT_W'(r_res_idx);
            r_out.payload_out <= r_res_pay ? r_pay_rd : '0;
            r_out.entry_count <= COUNT_W'(r_count);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_count     <= '0;
            r_addr      <= '0;
            r_cmp_en    <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_emp_found <= 1'b0;
            r_k_found   <= 1'b0;
            r_nk_found  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.issue;
            r_rd_vld <= r_vld[r_addr];
            if (i_cmd.capture) begin
                r_addr      <= '0;
                r_emp_found <= 1'b0;
                r_k_found   <= 1'b0;
                r_nk_found  <= 1'b0;
            end else begin
                if (i_cmd.issue) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (r_cmp_en && !r_rd_vld) begin
                    r_emp_found <= 1'b1;
                end
                if (r_cmp_en && hit_k) begin
                    r_k_found <= 1'b1;
                end
                if (r_cmp_en && hit_nk) begin
                    r_nk_found <= 1'b1;
                end
            end
            if (i_cmd.commit && set_vld) begin
                r_vld[wr_idx] <= 1'b1;
            end
            if (i_cmd.commit && clr_vld) begin
                r_vld[wr_idx] <= 1'b0;
            end
            if (i_cmd.commit && cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.commit && cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.addr_last = (r_addr == IW'(DEPTH - 1));
    assign o_sts.out_free  = !r_out_vld || !i_out_stall;
    assign o_out_valid     = r_out_vld;
    assign o_out_res       = r_out;

    // The entry count always equals the number of occupied slots.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_vld)))
        else $error("entry count differs from occupied slots");

    // An insert only ever lands on a slot that was empty.
    a_insert_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && set_vld) |-> !r_vld[wr_idx])
        else $error("insert overwrote an occupied slot");

    // A result only appears after the controller loaded it.
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(i_cmd.load))
        else $error("result valid rose without a load");

endmodule

// File: verif/tb_keyed_record_table.sv
// Self-checking testbench for the keyed record table (keyed_record_table).
// Depends on krt_pkg and the design files; runs a directed table, then
// random insert/rename/delete/search traffic checked against a shadow table.
`timescale 1ns / 100ps

module tb_keyed_record_table;

    import krt_pkg::*;

    localparam int DEPTH       = DEFAULT_DEPTH;
    localparam int TOTAL_ITEMS = 1850;
    localparam int POOL_SIZE   = 160;

    // Burst flavors of the random part.
    localparam int BURST_FILL   = 0;
    localparam int BURST_GROW   = 1;
    localparam int BURST_DRAIN  = 2;
    localparam int BURST_MIXED  = 3;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_stall;
    t_req in_req;
    logic out_valid;
    logic out_stall = 1'b0;
    t_res out_res;

    keyed_record_table #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_req   (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_res  (out_res)
    );

    // 8 ns clock.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Shadow copy of the table. A key of zero marks an empty slot here (the block
    // uses occupancy bits), so the first empty slot is found by searching for zero.
    logic [KEY_W-1:0] shadow_key [DEPTH];
    logic [PAY_W-1:0] shadow_payload [DEPTH];
    int               shadow_count;

    // Results owed by the block, oldest first.
    t_res answers_due[$];

    // Keys used by the random part. A pool somewhat larger than the table
    // lets the table fill up while still producing plenty of duplicates.
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int n_sent;
    int n_fail;
    int idle_phase;

    // Directed rows. Where typed is set, the result written in the row is the
    // one expected; otherwise the shadow table supplies it.
    typedef struct {
        t_req rq;
        bit   typed;
        t_res res;
    } t_dir_row;

    t_dir_row directed_rows[$];

    // First slot whose key equals k, or -1 if none does.
    function automatic int first_slot(input logic [KEY_W-1:0] k);
        for (int s = 0; s < DEPTH; s++) begin
            if (shadow_key[s] == k) begin
                return s;
            end
        end
        return -1;
    endfunction

    // Applies one request to the shadow table and returns the result the
    // block must give for it.
    function automatic t_res table_answer(input t_req rq);
        t_res             res;
        int               s;
        int               t;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] nk;
        k   = rq.key;
        nk  = rq.new_key;
        res = '0;
        res.status = ST_OK;
        // Key zero is never a valid argument; for a rename the new key is
        // checked as well.
        if (k == '0 || (rq.req_type == REQ_RENAME && nk == '0)) begin
            res.status = ST_INVALID;
        end else begin
            case (rq.req_type)
                REQ_INSERT: begin
                    // Fullness is checked before the duplicate test, so a full
                    // table answers full even for a key it already holds.
                    s = first_slot('0);
                    t = first_slot(k);
                    if (s < 0) begin
                        res.status = ST_FULL;
                    end else if (t >= 0) begin
                        res.status = ST_DUP;
                    end else begin
                        shadow_key[s]     = k;
                        shadow_payload[s] = rq.payload_in;
                        shadow_count++;
                        res.slot_index = SLOT_W'(s);
                    end
                end
                REQ_RENAME: begin
                    // Renaming onto itself counts as a duplicate too. The
                    // payload stays with the record.
                    s = first_slot(k);
                    if (s < 0) begin
                        res.status = ST_NOTFOUND;
                    end else if (first_slot(nk) >= 0) begin
                        res.status = ST_DUP;
                    end else begin
                        shadow_key[s]  = nk;
                        res.slot_index = SLOT_W'(s);
                    end
                end
                REQ_DELETE: begin
                    s = first_slot(k);
                    if (s < 0) begin
                        res.status = ST_NOTFOUND;
                    end else begin
                        shadow_key[s]     = '0;
                        shadow_payload[s] = '0;
                        if (shadow_count > 0) begin
                            shadow_count--;
                        end
                        res.slot_index = SLOT_W'(s);
                    end
                end
                default: begin
                    s = first_slot(k);
                    if (s < 0) begin
                        res.status = ST_NOTFOUND;
                    end else begin
                        res.slot_index  = SLOT_W'(s);
                        res.payload_out = shadow_payload[s];
                    end
                end
            endcase
        end
        res.entry_count = COUNT_W'(shadow_count);
        return res;
    endfunction

    // Random key: sometimes zero, sometimes any 32-bit value, mostly one
    // from the pool.
    function automatic logic [KEY_W-1:0] pick_key(input int zero_pct);
        int r;
        r = $urandom_range(99);
        if (r < zero_pct) begin
            return '0;
        end
        if (r < zero_pct + 12) begin
            return $urandom;
        end
        return key_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    // A key currently held by the table, so that renames, deletes and
    // searches succeed often.
    function automatic logic [KEY_W-1:0] pick_live_key();
        int s;
        if (shadow_count == 0) begin
            return pick_key(2);
        end
        do begin
            s = $urandom_range(DEPTH - 1);
        end while (shadow_key[s] == '0);
        return shadow_key[s];
    endfunction

    function automatic logic [PAY_W-1:0] pick_payload();
        int r;
        r = $urandom_range(99);
        if (r < 3) begin
            return '0;
        end
        if (r < 6) begin
            return '1;
        end
        return {$urandom, $urandom};
    endfunction

    // Offers one request and waits for it to be accepted. Valid is left high
    // afterwards: the next call either holds it for the next request or
    // lowers it for an idle cycle, so it is assigned once per time step.
    task automatic send_req(input t_req rq, input bit typed, input t_res typed_res);
        t_res model_res;
        idle_phase = (n_sent * 3) / TOTAL_ITEMS;
        if (idle_phase > 2) begin
            idle_phase = 2;
        end
        while ($urandom_range(99) < (idle_phase == 0 ? 18 : idle_phase == 1 ? 61 : 0)) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= rq;
        do begin
            @(posedge i_clk);
        end while (in_stall);
        model_res = table_answer(rq);
        answers_due.push_back(typed ? typed_res : model_res);
        n_sent++;
    endtask

    task automatic add_row(input logic [1:0] req, input logic [KEY_W-1:0] k,
                           input logic [KEY_W-1:0] nk, input logic [PAY_W-1:0] pay,
                           input bit typed, input logic [STATUS_W-1:0] st,
                           input int slot, input logic [PAY_W-1:0] pout, input int cnt);
        t_dir_row row;
        row.rq.req_type        = req;
        row.rq.key             = k;
        row.rq.new_key         = nk;
        row.rq.payload_in      = pay;
        row.typed              = typed;
        row.res.status         = st;
        row.res.slot_index     = SLOT_W'(slot);
        row.res.payload_out    = pout;
        row.res.entry_count    = COUNT_W'(cnt);
        directed_rows.push_back(row);
    endtask

    // Result side: compares every accepted result with the oldest one owed,
    // then draws the stall for the next cycle.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (answers_due.size() == 0) begin
                $error("result with none expected: status %0d slot %0d", out_res.status,
                       out_res.slot_index);
                n_fail++;
            end else begin
                want = answers_due.pop_front();
                if (out_res.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_res.status);
                    n_fail++;
                end
                if (out_res.slot_index !== want.slot_index) begin
                    $error("slot_index: expected %0d, got %0d", want.slot_index,
                           out_res.slot_index);
                    n_fail++;
                end
                if (out_res.payload_out !== want.payload_out) begin
                    $error("payload_out: expected %h, got %h", want.payload_out,
                           out_res.payload_out);
                    n_fail++;
                end
                if (out_res.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count,
                           out_res.entry_count);
                    n_fail++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < (idle_phase == 0 ? 61 : idle_phase == 1 ? 18 : 0));
    end

    // Hard limit on the run, several times the slowest expected run.
    initial begin
        #12_000_000;
        $display("keyed_record_table test failed");
        $finish;
    end

    initial begin
        t_req rq;
        int   kind;
        int   burst_len;
        int   r;
        int   ins_w;
        int   ren_w;
        int   del_w;
        t_res no_res;

        n_sent       = 0;
        n_fail       = 0;
        idle_phase   = 0;
        shadow_count = 0;
        no_res       = '0;
        for (int s = 0; s < DEPTH; s++) begin
            shadow_key[s]     = '0;
            shadow_payload[s] = '0;
        end
        // The key extremes sit in the pool next to random nonzero keys.
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'hFFFF_FFFF;
        key_pool[3] = 32'h0000_0001;
        for (int p = 4; p < POOL_SIZE; p++) begin
            do begin
                key_pool[p] = $urandom;
            end while (key_pool[p] == '0);
        end

        i_rst_n   <= 1'b0;
        in_valid  <= 1'b0;
        in_req    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty table, key extremes, every request type and
        // the invalid, duplicate and not-found refusals.
        add_row(REQ_SEARCH, 32'd5, 32'd0, 64'd0, 1, ST_NOTFOUND, 0, 64'd0, 0);
        add_row(REQ_INSERT, 32'd0, 32'd0, '1, 1, ST_INVALID, 0, 64'd0, 0);
        add_row(REQ_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, '1, 1, ST_OK, 0, 64'd0, 1);
        add_row(REQ_INSERT, 32'h7FFF_FFFF, 32'd0, 64'd0, 1, ST_OK, 1, 64'd0, 2);
        add_row(REQ_INSERT, 32'hFFFF_FFFF, 32'd0, 64'h0123_4567_89AB_CDEF, 1, ST_OK, 2,
                64'd0, 3);
        // A key already present is refused.
        add_row(REQ_INSERT, 32'h8000_0000, 32'd0, 64'd5, 1, ST_DUP, 0, 64'd0, 3);
        add_row(REQ_SEARCH, 32'h8000_0000, 32'd0, 64'd0, 1, ST_OK, 0, '1, 3);
        add_row(REQ_SEARCH, 32'hFFFF_FFFF, 32'd0, 64'd0, 0, ST_OK, 0, 64'd0, 0);
        // Zero as either key of a rename is invalid.
        add_row(REQ_RENAME, 32'hFFFF_FFFF, 32'd0, 64'd0, 1, ST_INVALID, 0, 64'd0, 3);
        add_row(REQ_RENAME, 32'd0, 32'd9, 64'd0, 1, ST_INVALID, 0, 64'd0, 3);
        // Renaming onto itself or onto another present key is a duplicate.
        add_row(REQ_RENAME, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'd0, 1, ST_DUP, 0, 64'd0, 3);
        add_row(REQ_RENAME, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 64'd0, 1, ST_DUP, 0, 64'd0, 3);
        add_row(REQ_RENAME, 32'd42, 32'd43, 64'd0, 1, ST_NOTFOUND, 0, 64'd0, 3);
        // A successful rename keeps the payload, which the search shows.
        add_row(REQ_RENAME, 32'hFFFF_FFFF, 32'd77, 64'd0, 0, ST_OK, 0, 64'd0, 0);
        add_row(REQ_SEARCH, 32'd77, 32'd0, 64'd0, 0, ST_OK, 0, 64'd0, 0);
        add_row(REQ_DELETE, 32'h8000_0000, 32'd0, 64'd0, 0, ST_OK, 0, 64'd0, 0);
        add_row(REQ_DELETE, 32'h8000_0000, 32'd0, 64'd0, 1, ST_NOTFOUND, 0, 64'd0, 2);
        add_row(REQ_SEARCH, 32'h8000_0000, 32'd0, 64'd0, 1, ST_NOTFOUND, 0, 64'd0, 2);
        add_row(REQ_DELETE, 32'd0, 32'd0, 64'd0, 1, ST_INVALID, 0, 64'd0, 2);
        add_row(REQ_SEARCH, 32'd0, 32'd0, 64'd0, 1, ST_INVALID, 0, 64'd0, 2);
        // The freed slot 0 is the first empty one again.
        add_row(REQ_INSERT, 32'd5, 32'd0, 64'hA5A5_5A5A_A5A5_5A5A, 0, ST_OK, 0, 64'd0, 0);
        add_row(REQ_SEARCH, 32'h7FFF_FFFF, 32'd0, 64'd0, 0, ST_OK, 0, 64'd0, 0);

        foreach (directed_rows[i]) begin
            send_req(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].res);
        end

        // Random part, in bursts. The first burst fills the table so that the
        // full case, including a full table with the key already present, is
        // reached early; later bursts grow, drain or mix at random.
        kind = BURST_FILL;
        while (n_sent < TOTAL_ITEMS) begin
            if (kind == BURST_FILL) begin
                while (shadow_count < DEPTH && n_sent < TOTAL_ITEMS) begin
                    rq.req_type   = REQ_INSERT;
                    rq.key        = $urandom;
                    rq.new_key    = $urandom;
                    rq.payload_in = pick_payload();
                    send_req(rq, 0, no_res);
                end
                rq.key = pick_live_key();
                send_req(rq, 0, no_res);
                rq.key = $urandom;
                send_req(rq, 0, no_res);
            end else begin
                case (kind)
                    BURST_GROW: begin
                        ins_w = 60;
                        ren_w = 72;
                        del_w = 84;
                    end
                    BURST_DRAIN: begin
                        ins_w = 15;
                        ren_w = 30;
                        del_w = 80;
                    end
                    default: begin
                        ins_w = 25;
                        ren_w = 50;
                        del_w = 75;
                    end
                endcase
                burst_len = $urandom_range(100, 30);
                for (int n = 0; n < burst_len && n_sent < TOTAL_ITEMS; n++) begin
                    r = $urandom_range(99);
                    rq.req_type   = (r < ins_w) ? REQ_INSERT :
                                    (r < ren_w) ? REQ_RENAME :
                                    (r < del_w) ? REQ_DELETE : REQ_SEARCH;
                    rq.new_key    = $urandom;
                    rq.payload_in = pick_payload();
                    if (rq.req_type == REQ_INSERT) begin
                        rq.key = ($urandom_range(99) < 15) ? pick_live_key() : pick_key(3);
                    end else begin
                        rq.key = ($urandom_range(99) < 65) ? pick_live_key() : pick_key(3);
                    end
                    if (rq.req_type == REQ_RENAME) begin
                        rq.new_key = ($urandom_range(99) < 10) ? pick_live_key() : pick_key(4);
                    end
                    send_req(rq, 0, no_res);
                end
            end
            r = $urandom_range(7);
            kind = (r == 0) ? BURST_FILL :
                   (r < 4)  ? BURST_GROW :
                   (r < 6)  ? BURST_DRAIN : BURST_MIXED;
        end

        in_valid <= 1'b0;
        while (answers_due.size() != 0) begin
            @(posedge i_clk);
        end
        // Let any stray result show up before the verdict.
        repeat (DEPTH + 8) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("keyed_record_table test passed");
        end else begin
            $display("keyed_record_table test failed");
        end
        $finish;
    end

endmodule
